FILE: rtl/ypcb_pkg.sv
// package: constants and types for the yaw pitch camera basis unit
package ypcb_pkg;
    localparam int AngleFracBits = 7;
    localparam int OutFracBits   = 15;
    localparam int OutW          = OutFracBits + 1;
    localparam int YawW          = 16;
    localparam int PitchW        = 15;
    localparam int LimitW        = 14;
    localparam int ChangeW       = 17;
    localparam int Turn          = 360 << AngleFracBits;
    localparam int Quarter       = 90 << AngleFracBits;
    localparam int MaxPitch      = 89 << AngleFracBits;
    localparam int QuarterW      = $clog2(Quarter + 1);
    localparam logic [31:0] PiQ30 = 32'd3373259426;
    localparam int Den           = 180 << AngleFracBits;
    localparam logic [30:0] OneQ30 = 31'h4000_0000;
    localparam logic [63:0] OutMax = (64'd1 << OutFracBits) - 64'd1;

    // serial multiplier: operand width and step counter width
    localparam int MulW   = 32;
    localparam int MulCntW = $clog2(MulW + 1);

    typedef logic signed [OutW-1:0] comp_t;

    // horner divisors by step
    function automatic logic [7:0] horner_div(input logic [2:0] i);
        case (i)
            3'd0: horner_div = 8'd156;
            3'd1: horner_div = 8'd110;
            3'd2: horner_div = 8'd72;
            3'd3: horner_div = 8'd42;
            3'd4: horner_div = 8'd20;
            default: horner_div = 8'd6;
        endcase
    endfunction
endpackage

FILE: rtl/ypcb_serial_mul.sv
// bit-serial unsigned 32x32 multiplier, one partial product per cycle
module ypcb_serial_mul
    import ypcb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MulW-1:0]   op_a,
    input  logic [MulW-1:0]   op_b,
    output logic              done,
    output logic [2*MulW-1:0] product
);
    logic [MulW-1:0]    a_reg, a_next;
    logic [MulW-1:0]    b_reg, b_next;
    logic [2*MulW-1:0]  acc_reg, acc_next;
    logic [MulCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // msb first: shift accumulator, add multiplicand on a one bit
            acc_next = {acc_reg[2*MulW-2:0], 1'b0}
                     + (b_reg[MulW-1] ? {{MulW{1'b0}}, a_reg} : '0);
            b_next   = {b_reg[MulW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MulCntW'(MulW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: rtl/yaw_pitch_camera_basis_unit.sv
// top level: yaw pitch camera basis unit
//
// s_ channel: one transfer carries a pitch change and a yaw change in
// 1/128 degree. the unit adds them to its stored angles, wraps yaw into
// one turn and clamps pitch to +/- min(pitch_limit, 89 degrees).
// m_ channel: one transfer per input carries front, up, right and
// horizontal front vectors in q1.15 plus the new yaw and pitch.
// cfg_we/cfg_wdata write pitch_limit at once; the user must do so only
// while idle, as the block itself does not enforce this. one item at a
// time: four quarter sines (yaw, 90-yaw, pitch, 90-pitch) each run radian
// conversion, square, six horner products, final product, plus four
// basis products, all on one bit-serial 32x32 multiplier. each horner
// step divides on a restoring divider, and the degree to radian
// conversion is a 48-bit restoring divide on the same divider.
// s_ready is high whenever the unit is idle; a stalled m_ready holds the
// result, the next item is still taken and computed, then waits for the
// result register to empty, which keeps s_ready low.
// reset (synchronous, active low) zeroes both angles, restores the 89
// degree limit and empties the result register.
module yaw_pitch_camera_basis_unit
    import ypcb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [LimitW-1:0]         cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ChangeW-1:0] s_pitch_change,
    input  logic signed [ChangeW-1:0] s_yaw_change,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OutW-1:0]    m_front_x,
    output logic signed [OutW-1:0]    m_front_y,
    output logic signed [OutW-1:0]    m_front_z,
    output logic signed [OutW-1:0]    m_up_x,
    output logic signed [OutW-1:0]    m_up_y,
    output logic signed [OutW-1:0]    m_up_z,
    output logic signed [OutW-1:0]    m_right_x,
    output logic signed [OutW-1:0]    m_right_z,
    output logic signed [OutW-1:0]    m_walk_front_x,
    output logic signed [OutW-1:0]    m_walk_front_z,
    output logic [YawW-1:0]           m_yaw_now,
    output logic signed [PitchW-1:0]  m_pitch_now
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_ANGLE, ST_QSEL, ST_RAD_DIV, ST_SQ, ST_HMUL, ST_HDIV,
        ST_SMUL, ST_SROUND, ST_PMUL, ST_PSTORE, ST_OUT
    } state_t;

    localparam int RadW  = 48;   // r * pi_q30 + den/2 fits in 48 bits
    localparam int RadCntW = $clog2(RadW + 1);

    state_t state_reg;
    logic [LimitW-1:0]        limit_reg;
    logic [YawW-1:0]          yaw_reg;
    logic signed [PitchW-1:0] pitch_reg;
    logic signed [ChangeW-1:0] dp_reg, dy_reg;
    logic [1:0]               sel_reg;      // which quarter sine is running
    logic [QuarterW-1:0]      r_reg;
    logic [1:0]               qy_reg, qp_reg;
    logic [QuarterW-1:0]      ry_reg, rp_reg;
    logic [OutW-1:0]          s_tab_reg [4];
    // restoring divider shared by radian conversion and horner steps
    logic [RadW-1:0]          dq_reg;       // dividend shifting out, quotient in
    logic [RadW-1:0]          drem_reg;
    logic [RadCntW-1:0]       dcnt_reg;
    logic [30:0]              x_reg, t_reg;
    logic [31:0]              x2_reg;       // x squared reaches about 2.47 in q30
    logic [2:0]               hstep_reg;
    logic [1:0]               pstep_reg;
    logic                     mstart_reg;
    logic                     out_full_reg;
    comp_t sy_reg, cy_reg, sp_reg, cp_reg;
    comp_t prod_reg [4];
    logic [YawW-1:0]          yaw_now_reg;
    logic signed [PitchW-1:0] pitch_now_reg;
    comp_t o_reg [10];

    logic [MulW-1:0]   mul_a, mul_b;
    logic              mul_done;
    logic [2*MulW-1:0] mul_p;

    ypcb_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart_reg),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // angle update
    logic signed [ChangeW+1:0] lim_s, p_sum, y_sum;
    logic signed [ChangeW+1:0] p_new, y_w1;
    logic [YawW-1:0]           y_new;
    always_comb begin
        lim_s = (limit_reg > LimitW'(MaxPitch)) ? (ChangeW+2)'(MaxPitch)
                                                  : (ChangeW+2)'(limit_reg);
        p_sum = (ChangeW+2)'(pitch_reg) + (ChangeW+2)'(dp_reg);
        p_new = p_sum;
        if (p_sum > lim_s)  p_new = lim_s;
        if (p_sum < -lim_s) p_new = -lim_s;
        // yaw in [0,turn) plus change in [-65536,65535]: two corrections
        y_sum = (ChangeW+2)'($signed({1'b0, yaw_reg})) + (ChangeW+2)'(dy_reg);
        y_w1  = y_sum;
        if (y_w1 < 0) y_w1 = y_w1 + (ChangeW+2)'(Turn);
        else if (y_w1 >= (ChangeW+2)'(Turn)) y_w1 = y_w1 - (ChangeW+2)'(Turn);
        if (y_w1 < 0) y_w1 = y_w1 + (ChangeW+2)'(Turn);
        else if (y_w1 >= (ChangeW+2)'(Turn)) y_w1 = y_w1 - (ChangeW+2)'(Turn);
        y_new = YawW'(y_w1);
    end

    // quadrant split of yaw and of pitch mapped into one turn
    logic [YawW-1:0] pa;
    logic [1:0] qy, qp;
    logic [QuarterW-1:0] ry, rp;
    always_comb begin
        pa = pitch_reg[PitchW-1] ? YawW'(Turn) + YawW'($signed(pitch_reg))
                                  : YawW'(pitch_reg);
        qy = 2'd0; ry = QuarterW'(yaw_reg);
        if (yaw_reg >= YawW'(3*Quarter)) begin
            qy = 2'd3; ry = QuarterW'(yaw_reg - YawW'(3*Quarter));
        end else if (yaw_reg >= YawW'(2*Quarter)) begin
            qy = 2'd2; ry = QuarterW'(yaw_reg - YawW'(2*Quarter));
        end else if (yaw_reg >= YawW'(Quarter)) begin
            qy = 2'd1; ry = QuarterW'(yaw_reg - YawW'(Quarter));
        end
        qp = 2'd0; rp = QuarterW'(pa);
        if (pa >= YawW'(3*Quarter)) begin
            qp = 2'd3; rp = QuarterW'(pa - YawW'(3*Quarter));
        end else if (pa >= YawW'(2*Quarter)) begin
            qp = 2'd2; rp = QuarterW'(pa - YawW'(2*Quarter));
        end else if (pa >= YawW'(Quarter)) begin
            qp = 2'd1; rp = QuarterW'(pa - YawW'(Quarter));
        end
    end

    // one restoring division step
    logic [RadW:0]   d_trial;
    logic [RadW-1:0] d_shift;
    logic [RadW-1:0] d_den;
    always_comb begin
        d_den   = (state_reg == ST_RAD_DIV) ? RadW'(Den)
                                            : RadW'(horner_div(hstep_reg));
        d_shift = {drem_reg[RadW-2:0], dq_reg[RadW-1]};
        d_trial = {1'b0, d_shift} - {1'b0, d_den};
    end

    // multiplier operands by state, sampled when the start pulse is seen
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RAD_DIV: begin mul_a = MulW'(r_reg);  mul_b = PiQ30;         end
            ST_SQ:    begin mul_a = MulW'(x_reg);  mul_b = MulW'(x_reg);  end
            ST_HMUL:  begin mul_a = MulW'(x2_reg); mul_b = MulW'(t_reg);  end
            ST_SMUL:  begin mul_a = MulW'(x_reg);  mul_b = MulW'(t_reg);  end
            ST_PMUL: begin
                case (pstep_reg)
                    2'd0: begin mul_a = MulW'(cy_reg); mul_b = MulW'(cp_reg); end
                    2'd1: begin mul_a = MulW'(sy_reg); mul_b = MulW'(cp_reg); end
                    2'd2: begin mul_a = MulW'(cy_reg); mul_b = MulW'(sp_reg); end
                    default: begin mul_a = MulW'(sy_reg); mul_b = MulW'(sp_reg); end
                endcase
                // magnitudes only; sign fixed afterwards
                mul_a = mul_a[OutW-1] ? MulW'(-$signed(mul_a[OutW-1:0]))
                                      : MulW'(mul_a[OutW-1:0]);
                mul_b = mul_b[OutW-1] ? MulW'(-$signed(mul_b[OutW-1:0]))
                                      : MulW'(mul_b[OutW-1:0]);
            end
            default: ;
        endcase
    end

    // signed product rounding: floor((a*b + half) >> frac)
    logic               p_neg;
    logic [2*MulW-1:0]  p_mag;
    logic signed [2*MulW:0] p_sgn, p_rnd;
    comp_t               p_out;
    always_comb begin
        case (pstep_reg)
            2'd0: p_neg = cy_reg[OutW-1] ^ cp_reg[OutW-1];
            2'd1: p_neg = sy_reg[OutW-1] ^ cp_reg[OutW-1];
            2'd2: p_neg = cy_reg[OutW-1] ^ sp_reg[OutW-1];
            default: p_neg = sy_reg[OutW-1] ^ sp_reg[OutW-1];
        endcase
        p_mag = mul_p;
        p_sgn = p_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
        p_rnd = (p_sgn + $signed((2*MulW+1)'(1) <<< (OutFracBits - 1)))
                >>> OutFracBits;
        p_out = OutW'(p_rnd);
    end

    // quarter sine rounding
    logic [30:0]   s_full;
    logic [30:0]   s_rnd;
    logic [OutW-1:0] s_sat;
    always_comb begin
        s_full = 31'(mul_p >> 30);
        s_rnd  = (s_full + 31'(1 << (30 - OutFracBits - 1))) >> (30 - OutFracBits);
        s_sat  = (64'(s_rnd) > OutMax) ? OutW'(OutMax) : OutW'(s_rnd);
    end

    // sign and swap from quadrant
    function automatic comp_t pick_sin(input logic [1:0] q, input logic [OutW-1:0] s,
                                       input logic [OutW-1:0] c);
        case (q)
            2'd0: pick_sin = comp_t'(s);
            2'd1: pick_sin = comp_t'(c);
            2'd2: pick_sin = -comp_t'(s);
            default: pick_sin = -comp_t'(c);
        endcase
    endfunction
    function automatic comp_t pick_cos(input logic [1:0] q, input logic [OutW-1:0] s,
                                       input logic [OutW-1:0] c);
        case (q)
            2'd0: pick_cos = comp_t'(c);
            2'd1: pick_cos = -comp_t'(s);
            2'd2: pick_cos = -comp_t'(c);
            default: pick_cos = comp_t'(s);
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            limit_reg    <= LimitW'(MaxPitch);
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            out_full_reg <= 1'b0;
            mstart_reg   <= 1'b0;
        end else begin
            mstart_reg <= 1'b0;
            if (cfg_we) limit_reg <= cfg_wdata;
            if (out_full_reg && m_ready) out_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        dp_reg    <= s_pitch_change;
                        dy_reg    <= s_yaw_change;
                        state_reg <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    yaw_reg   <= y_new;
                    pitch_reg <= PitchW'(p_new);
                    sel_reg   <= 2'd0;
                    state_reg <= ST_QSEL;
                    // quadrants taken next cycle from updated angles
                end
                ST_QSEL: begin
                    // sel 0: sin(ry) 1: sin(90-ry) 2: sin(rp) 3: sin(90-rp)
                    qy_reg <= qy; ry_reg <= ry;
                    qp_reg <= qp; rp_reg <= rp;
                    case (sel_reg)
                        2'd0: r_reg <= ry;
                        2'd1: r_reg <= QuarterW'(Quarter) - ry;
                        2'd2: r_reg <= rp;
                        default: r_reg <= QuarterW'(Quarter) - rp;
                    endcase
                    mstart_reg <= 1'b1;
                    state_reg  <= ST_RAD_DIV;
                    dcnt_reg   <= '0;
                    hstep_reg  <= '0;
                end
                ST_RAD_DIV: begin
                    // wait for r*pi product, then divide bit by bit
                    if (mul_done) begin
                        dq_reg   <= RadW'(mul_p) + RadW'(Den / 2);
                        drem_reg <= '0;
                        dcnt_reg <= RadCntW'(1);
                    end else if (dcnt_reg != '0) begin
                        drem_reg <= d_trial[RadW] ? d_shift : d_trial[RadW-1:0];
                        dq_reg   <= {dq_reg[RadW-2:0], ~d_trial[RadW]};
                        dcnt_reg <= dcnt_reg + 1'b1;
                        if (dcnt_reg == RadCntW'(RadW)) begin
                            x_reg      <= {dq_reg[29:0], ~d_trial[RadW]};
                            mstart_reg <= 1'b1;
                            state_reg  <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (mul_done) begin
                        x2_reg     <= 32'(mul_p >> 30);
                        t_reg      <= OneQ30;
                        mstart_reg <= 1'b1;
                        state_reg  <= ST_HMUL;
                    end
                end
                ST_HMUL: begin
                    if (mul_done) begin
                        dq_reg    <= RadW'(mul_p >> 30) << (RadW - 32);
                        drem_reg  <= '0;
                        dcnt_reg  <= RadCntW'(1);
                        state_reg <= ST_HDIV;
                    end
                end
                ST_HDIV: begin
                    drem_reg <= d_trial[RadW] ? d_shift : d_trial[RadW-1:0];
                    dq_reg   <= {dq_reg[RadW-2:0], ~d_trial[RadW]};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == RadCntW'(32)) begin
                        t_reg      <= OneQ30 - {dq_reg[29:0], ~d_trial[RadW]};
                        hstep_reg  <= hstep_reg + 1'b1;
                        mstart_reg <= 1'b1;
                        state_reg  <= (hstep_reg == 3'd5) ? ST_SMUL : ST_HMUL;
                    end
                end
                ST_SMUL: begin
                    if (mul_done) state_reg <= ST_SROUND;
                end
                ST_SROUND: begin
                    s_tab_reg[sel_reg] <= s_sat;
                    sel_reg <= sel_reg + 1'b1;
                    if (sel_reg == 2'd3) begin
                        sy_reg <= pick_sin(qy_reg, s_tab_reg[0], s_tab_reg[1]);
                        cy_reg <= pick_cos(qy_reg, s_tab_reg[0], s_tab_reg[1]);
                        sp_reg <= pick_sin(qp_reg, s_tab_reg[2], s_sat);
                        cp_reg <= pick_cos(qp_reg, s_tab_reg[2], s_sat);
                        pstep_reg  <= '0;
                        mstart_reg <= 1'b1;
                        state_reg  <= ST_PMUL;
                    end else begin
                        state_reg <= ST_QSEL;
                    end
                end
                ST_PMUL: begin
                    if (mul_done) state_reg <= ST_PSTORE;
                end
                ST_PSTORE: begin
                    prod_reg[pstep_reg] <= p_out;
                    pstep_reg <= pstep_reg + 1'b1;
                    if (pstep_reg == 2'd3) begin
                        state_reg <= ST_OUT;
                    end else begin
                        mstart_reg <= 1'b1;
                        state_reg  <= ST_PMUL;
                    end
                end
                ST_OUT: begin
                    if (!out_full_reg) begin
                        o_reg[0] <= prod_reg[0];
                        o_reg[1] <= sp_reg;
                        o_reg[2] <= prod_reg[1];
                        o_reg[3] <= -prod_reg[2];
                        o_reg[4] <= cp_reg;
                        o_reg[5] <= -prod_reg[3];
                        o_reg[6] <= -sy_reg;
                        o_reg[7] <= cy_reg;
                        o_reg[8] <= cy_reg;
                        o_reg[9] <= sy_reg;
                        yaw_now_reg   <= yaw_reg;
                        pitch_now_reg <= pitch_reg;
                        out_full_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_full_reg;
    assign m_front_x      = o_reg[0];
    assign m_front_y      = o_reg[1];
    assign m_front_z      = o_reg[2];
    assign m_up_x         = o_reg[3];
    assign m_up_y         = o_reg[4];
    assign m_up_z         = o_reg[5];
    assign m_right_x      = o_reg[6];
    assign m_right_z      = o_reg[7];
    assign m_walk_front_x = o_reg[8];
    assign m_walk_front_z = o_reg[9];
    assign m_yaw_now      = yaw_now_reg;
    assign m_pitch_now    = pitch_now_reg;
endmodule

FILE: rtl/ypcb_checker.sv
// port checker for the yaw pitch camera basis unit, with its bind
module ypcb_checker
    import ypcb_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [YawW-1:0]          m_yaw_now,
    input logic signed [PitchW-1:0] m_pitch_now,
    input logic signed [OutW-1:0]   m_right_z,
    input logic signed [OutW-1:0]   m_walk_front_x
);
    // one item in work at a time: a transfer drops s_ready
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");
    // result stays until taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_yaw_now))
        else $error("result dropped or changed under stall");
    // yaw always within one turn
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_yaw_now < YawW'(Turn))
        else $error("yaw out of range");
    // pitch stays inside 89 degrees
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_now <= PitchW'(MaxPitch)) && (m_pitch_now >= -PitchW'(MaxPitch)))
        else $error("pitch out of range");
    // right z and walk x are both cos of yaw
    a_cos_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_right_z == m_walk_front_x)
        else $error("yaw cosine mismatch");
endmodule

bind yaw_pitch_camera_basis_unit ypcb_checker u_ypcb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_yaw_now      (m_yaw_now),
    .m_pitch_now    (m_pitch_now),
    .m_right_z      (m_right_z),
    .m_walk_front_x (m_walk_front_x)
);
